FILE: rtl/core/olt_pkg.sv
`default_nettype none

package olt_pkg;

    localparam int unsigned CmdW   = 3;
    localparam int unsigned PosW   = 7;
    localparam int unsigned ValW   = 32;
    localparam int unsigned GrpSz  = 8;
    localparam int unsigned GrpIdxW = 3;

    localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CmdW-1:0] CMD_INSERT = 3'd1;
    localparam logic [CmdW-1:0] CMD_DELETE = 3'd2;
    localparam logic [CmdW-1:0] CMD_READ   = 3'd3;
    localparam logic [CmdW-1:0] CMD_LOCATE = 3'd4;

    typedef logic [ValW-1:0] t_word;

    // Per-beat instruction broadcast to every cell of the chain.
    typedef struct packed {
        logic cap;   // beat accepted: capture taps and match bits
        logic ins;   // shift up from the selected cell, load the new value there
        logic del;   // shift down from the selected cell
        logic rd;    // selected cell drives its entry onto the tap
    } t_cell_op;

endpackage

`default_nettype wire

FILE: rtl/core/ordered_list_table_core.sv
// A command beat passes the cell chain, which captures its taps and match bits at
// acceptance, then the group registers of the two-level reduction tree, then the
// output registers. A new beat is taken once the previous result is loaded there;
// a stalled result holds off the next beat.
// Reset (synchronous, active low) empties the list and drops any beat in flight;
// the entry cells themselves are not cleared.
`default_nettype none

module ordered_list_table_core #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire [2:0]            i_cmd,
    input  wire [6:0]            i_position,
    input  wire signed [31:0]    i_item_value,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_ok,
    output logic signed [31:0]   o_value_out,
    output logic [6:0]           o_found_position,
    output logic [6:0]           o_count,
    output logic                 o_is_empty
);

    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH+1);
    localparam int unsigned CMPW = ((CW > olt_pkg::PosW) ? CW : olt_pkg::PosW) + 1;
    localparam logic [CMPW-1:0] DepthC = CMPW'(DEPTH);

    typedef struct packed {
        logic          ok;
        logic          loc;
        logic [CW-1:0] count;
    } t_meta;

    logic            r_s1;
    logic            r_s2;
    logic            r_out_valid;
    logic [CW-1:0]   r_count;
    t_meta           r_s1_meta;
    t_meta           r_s2_meta;

    logic            w_accept;
    logic [CMPW-1:0] w_pos;
    logic [CMPW-1:0] w_cnt;
    logic [CMPW-1:0] w_pos_m1;
    logic            w_pos_nz;
    logic            w_ok;
    logic [CW-1:0]   n_count;
    olt_pkg::t_cell_op w_op;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_pos    = CMPW'(i_position);
    assign w_cnt    = CMPW'(r_count);
    assign w_pos_m1 = w_pos - CMPW'(1);
    assign w_pos_nz = (w_pos != '0);

    always_comb begin
        w_ok    = 1'b0;
        n_count = r_count;
        w_op    = '0;
        w_op.cap = w_accept;
        case (i_cmd)
            olt_pkg::CMD_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            olt_pkg::CMD_INSERT: begin
                w_ok = w_pos_nz && (w_pos <= w_cnt + CMPW'(1)) && (w_cnt < DepthC);
                if (w_ok) begin
                    n_count  = r_count + CW'(1);
                    w_op.ins = w_accept;
                end
            end
            olt_pkg::CMD_DELETE: begin
                w_ok = w_pos_nz && (w_pos <= w_cnt);
                if (w_ok) begin
                    n_count  = r_count - CW'(1);
                    w_op.del = w_accept;
                    w_op.rd  = 1'b1;
                end
            end
            olt_pkg::CMD_READ: begin
                w_ok    = w_pos_nz && (w_pos <= w_cnt);
                w_op.rd = w_ok;
            end
            olt_pkg::CMD_LOCATE: begin
                w_ok = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // Cell chain: each cell sees its neighbors' entries; the first cell sees zero on its left, the last its own entry.
    olt_pkg::t_word w_entry [DEPTH];
    olt_pkg::t_word w_tap   [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic [IW-1:0]    w_sel;

    assign w_sel = IW'(w_pos_m1);

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        olt_pkg::t_word w_left;
        olt_pkg::t_word w_right;
        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_entry[gi];
        end else begin : g_mid_r
            assign w_right = w_entry[gi+1];
        end
        olt_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_sel   (w_sel),
            .i_count (r_count),
            .i_val   (i_item_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[gi]),
            .o_tap   (w_tap[gi]),
            .o_match (w_match[gi])
        );
    end

    olt_pkg::t_word w_red_data;
    logic           w_red_any;
    logic [IW-1:0]  w_red_idx;

    olt_reduce #(
        .DEPTH (DEPTH)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_en    (r_s1),
        .i_taps  (w_tap),
        .i_match (w_match),
        .o_data  (w_red_data),
        .o_any   (w_red_any),
        .o_index (w_red_idx)
    );

    logic        w_out_load;
    logic [IW:0] w_fpos;

    assign w_out_load = r_s2 && (!r_out_valid || !i_out_stall);
    assign w_fpos     = {1'b0, w_red_idx} + (IW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_s1 <= w_accept;
            if (r_s1) begin
                r_s2 <= 1'b1;
            end else if (w_out_load) begin
                r_s2 <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_meta.ok    <= w_ok;
            r_s1_meta.loc   <= (i_cmd == olt_pkg::CMD_LOCATE);
            r_s1_meta.count <= n_count;
        end
        if (r_s1) begin
            r_s2_meta <= r_s1_meta;
        end
        if (w_out_load) begin
            o_ok             <= r_s2_meta.ok;
            o_value_out      <= w_red_data;
            o_found_position <= (r_s2_meta.loc && w_red_any) ? 7'(w_fpos) : 7'd0;
            o_count          <= 7'(r_s2_meta.count);
            o_is_empty       <= (r_s2_meta.count == '0);
        end
    end

    // One command in flight at a time.
    assign o_in_stall  = r_s1 || r_s2;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/olt_cell.sv
`default_nettype none

module olt_cell #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX   = 0
) (
    input  wire                          i_clk,
    input  olt_pkg::t_cell_op            i_op,
    input  wire [$clog2(DEPTH)-1:0]      i_sel,
    input  wire [$clog2(DEPTH+1)-1:0]    i_count,
    input  olt_pkg::t_word               i_val,
    input  olt_pkg::t_word               i_left,
    input  olt_pkg::t_word               i_right,
    output olt_pkg::t_word               o_entry,
    output olt_pkg::t_word               o_tap,
    output logic                         o_match
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);
    localparam logic [IW-1:0] IdxC   = IW'(IDX);
    localparam logic [CW-1:0] IdxCnt = CW'(IDX);

    olt_pkg::t_word r_entry;
    olt_pkg::t_word n_entry;
    olt_pkg::t_word r_tap;
    logic           r_match;

    always_comb begin
        n_entry = r_entry;
        if (i_op.ins) begin
            if (IdxC == i_sel) begin
                n_entry = i_val;
            end else if (IdxC > i_sel) begin
                n_entry = i_left;
            end
        end else if (i_op.del) begin
            if (IdxC >= i_sel) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_op.cap) begin
            r_tap   <= (i_op.rd && (IdxC == i_sel)) ? r_entry : '0;
            r_match <= (r_entry == i_val) && (IdxCnt < i_count);
        end
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;
    assign o_match = r_match;

endmodule

`default_nettype wire

FILE: rtl/core/olt_reduce.sv
`default_nettype none

module olt_reduce #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  olt_pkg::t_word               i_taps [DEPTH],
    input  wire [DEPTH-1:0]              i_match,
    output olt_pkg::t_word               o_data,
    output logic                         o_any,
    output logic [$clog2(DEPTH)-1:0]     o_index
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned NG = (DEPTH + olt_pkg::GrpSz - 1) / olt_pkg::GrpSz;
    localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;

    olt_pkg::t_word                    r_grp_data [NG];
    logic [NG-1:0]                     r_grp_any;
    logic [olt_pkg::GrpIdxW-1:0]       r_grp_idx  [NG];

    olt_pkg::t_word                    n_grp_data [NG];
    logic [NG-1:0]                     n_grp_any;
    logic [olt_pkg::GrpIdxW-1:0]       n_grp_idx  [NG];

    // First level: eight cells per group, the lowest matching cell wins.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp_data[g] = '0;
            n_grp_any[g]  = 1'b0;
            n_grp_idx[g]  = '0;
            for (int j = olt_pkg::GrpSz - 1; j >= 0; j--) begin
                if (g * olt_pkg::GrpSz + j < DEPTH) begin
                    n_grp_data[g] = n_grp_data[g] | i_taps[g * olt_pkg::GrpSz + j];
                    if (i_match[g * olt_pkg::GrpSz + j]) begin
                        n_grp_any[g] = 1'b1;
                        n_grp_idx[g] = olt_pkg::GrpIdxW'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp_data <= n_grp_data;
            r_grp_any  <= n_grp_any;
            r_grp_idx  <= n_grp_idx;
        end
    end

    // Second level: the taps are one-hot, so an OR merges them; the lowest matching group gives the index.
    logic [GW-1:0]               w_gsel;
    logic [olt_pkg::GrpIdxW-1:0] w_lsel;

    always_comb begin
        o_data = '0;
        w_gsel = '0;
        w_lsel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            o_data = o_data | r_grp_data[g];
            if (r_grp_any[g]) begin
                w_gsel = GW'(g);
                w_lsel = r_grp_idx[g];
            end
        end
    end

    assign o_any   = |r_grp_any;
    assign o_index = IW'({w_gsel, w_lsel});

endmodule

`default_nettype wire

FILE: rtl/core/olt_checker.sv
`default_nettype none

module olt_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_in_valid,
    input wire         o_in_stall,
    input wire         o_out_valid,
    input wire         i_out_stall,
    input wire         o_ok,
    input wire [31:0]  o_value_out,
    input wire [6:0]   o_found_position,
    input wire [6:0]   o_count,
    input wire         o_is_empty
);

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_count == 7'd0)))
        else $error("empty flag disagrees with count");

    // A locate hit is a successful command that returns no value.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_found_position != 7'd0) |-> o_ok && (o_value_out == 32'd0))
        else $error("found position on a non-locate result");

    // After an accepted command beat the input side is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a command is in flight");

endmodule

bind ordered_list_table_core olt_checker u_olt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_ok             (o_ok),
    .o_value_out      (o_value_out),
    .o_found_position (o_found_position),
    .o_count          (o_count),
    .o_is_empty       (o_is_empty)
);

`default_nettype wire
